// File: hw/rtl/srsw_pkg.sv
// Shared types, codes and helpers of the selective-repeat sender window.
// No dependencies; imported by srsw_ctrl, srsw_dp and the top level.
package srsw_pkg;

  localparam int PIECES      = 16;
  localparam int CHUNK_SHIFT = 14;
  localparam int CHUNK_LEN   = 16384;
  localparam int LD_STEPS    = 18;  // length setup, 17 count steps, then commit

  localparam int IN_DW  = 80;
  localparam int OUT_DW = 48;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic KIND_PIECE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] CFG_TOTAL  = 3'd0;
  localparam logic [2:0] CFG_STRIDE = 3'd1;
  localparam logic [2:0] CFG_RETX   = 3'd2;
  localparam logic [2:0] CFG_FAST   = 3'd3;
  localparam logic [2:0] CFG_BURST  = 3'd4;

  typedef struct packed {
    logic       latch;
    logic       arm;
    logic       jump;
    logic       shift;
    logic       ld_all;
    logic       ld_run;
    logic       ack_apply;
    logic       push_status;
    logic [1:0] code;
    logic       sc_init;
    logic       sc_next_slot;
    logic       sc_next_piece;
    logic       sc_read;
    logic       sc_take;
    logic       sc_flush;
  } srsw_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       active;
    logic       start_bad;
    logic       ack_bad;
    logic       at_frontier;
    logic       far_jump;
    logic       ld_fin;
    logic       sc_end;
    logic       sc_skip_slot;
    logic       sc_skip_piece;
    logic       sc_emit;
    logic       pend_valid;
    logic       out_free;
  } srsw_stat_t;

  // zero means never sent, so a zero clock reading is stored as one
  function automatic logic [31:0] stamp(input logic [31:0] t);
    return (t == 32'd0) ? 32'd1 : t;
  endfunction

endpackage

// File: hw/rtl/srsw_ctrl.sv
// Sequencing state machine of the sender window.
// Depends on srsw_pkg; drives srsw_dp through command/status structs.
module srsw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  srsw_pkg::srsw_stat_t stat,
  output srsw_pkg::srsw_cmd_t  cmd
);
  import srsw_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DECODE  = 12'b000000000010,
    S_ARM     = 12'b000000000100,
    S_JUMP    = 12'b000000001000,
    S_SHIFT   = 12'b000000010000,
    S_LDA     = 12'b000000100000,
    S_LOAD    = 12'b000001000000,
    S_ACK     = 12'b000010000000,
    S_PUSH    = 12'b000100000000,
    S_SC_ADDR = 12'b001000000000,
    S_SC_EVAL = 12'b010000000000,
    S_FLUSH   = 12'b100000000000
  } state_t;

  state_t     state_r, state_nxt;
  state_t     ret_r, ret_nxt;
  logic [1:0] code_r, code_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_START: begin
            if (stat.start_bad) begin
              code_nxt  = ST_REFUSED;
              state_nxt = S_PUSH;
            end else begin
              state_nxt = S_ARM;
            end
          end
          OP_ACK: begin
            if (stat.ack_bad) begin
              code_nxt  = ST_IGNORED;
              state_nxt = S_PUSH;
            end else if (stat.at_frontier) begin
              state_nxt = S_ACK;
            end else if (stat.far_jump) begin
              state_nxt = S_JUMP;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
          OP_TICK: begin
            if (stat.active) begin
              cmd.sc_init = 1'b1;
              state_nxt   = S_SC_ADDR;
            end else begin
              state_nxt = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ARM: begin
        cmd.arm   = 1'b1;
        code_nxt  = ST_OK;
        ret_nxt   = S_PUSH;
        state_nxt = S_LDA;
      end
      S_JUMP: begin
        cmd.jump  = 1'b1;
        ret_nxt   = S_DECODE;
        state_nxt = S_LDA;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        ret_nxt   = S_DECODE;
        state_nxt = S_LOAD;
      end
      S_LDA: begin
        cmd.ld_all = 1'b1;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.ld_run = 1'b1;
        if (stat.ld_fin) state_nxt = ret_r;
      end
      S_ACK: begin
        cmd.ack_apply = 1'b1;
        code_nxt      = ST_OK;
        state_nxt     = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_SC_ADDR: begin
        if (stat.sc_end) begin
          state_nxt = S_FLUSH;
        end else if (stat.sc_skip_slot) begin
          cmd.sc_next_slot = 1'b1;
        end else if (stat.sc_skip_piece) begin
          cmd.sc_next_piece = 1'b1;
        end else begin
          cmd.sc_read = 1'b1;
          state_nxt   = S_SC_EVAL;
        end
      end
      S_SC_EVAL: begin
        if (!stat.sc_emit) begin
          cmd.sc_next_piece = 1'b1;
          state_nxt         = S_SC_ADDR;
        end else if (!stat.pend_valid || stat.out_free) begin
          cmd.sc_take = 1'b1;
          state_nxt   = S_SC_ADDR;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.sc_flush = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// File: hw/rtl/srsw_dp.sv
// Datapath of the sender window: config, window slots, send-stamp memory,
// slot loader, tick scan and the output register. Depends on srsw_pkg.
module srsw_dp #(
  parameter int W         = 8,
  parameter int MAX_BURST = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [srsw_pkg::IN_DW-1:0]   in_tdata,
  input  logic [1:0]                   in_tuser,
  input  logic                         cfg_valid,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data,
  input  srsw_pkg::srsw_cmd_t          cmd,
  output srsw_pkg::srsw_stat_t         stat,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [srsw_pkg::OUT_DW-1:0]  out_tdata,
  output logic                         out_tuser,
  output logic                         out_tlast
);
  import srsw_pkg::*;

  localparam int WI = (W > 1) ? $clog2(W) : 1;
  localparam int WC = $clog2(W + 1);
  localparam int AW = $clog2(W * PIECES);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int MD = W * PIECES;

  // configuration
  logic [31:0] total_r;
  logic [10:0] stride_r;
  logic [15:0] retx_r, fast_r;
  logic [5:0]  burst_r;

  // latched item
  logic [1:0]  op_r;
  logic [31:0] front_r, now_r;
  logic [15:0] bits_r;

  // transfer state
  logic          active_r, finished_r;
  logic [18:0]   ccount_r, base_r;
  logic [31:0]   txlen_r;
  logic [WI-1:0] head_r;

  logic          valid_r [W];
  logic [4:0]    pcs_r   [W];
  logic [15:0]   acked_r [W];
  logic [31:0]   atime_r [W];

  logic [31:0]   sent_mem [MD];
  logic [31:0]   rd_r;

  // slot loader
  logic [WC-1:0] ld_cnt_r;
  logic [4:0]    ld_step_r;
  logic [WI-1:0] ld_phys_r;
  logic [19:0]   ld_chunk_r;
  logic          ld_in_r;
  logic [14:0]   ld_len_r;
  logic [15:0]   ld_acc_r;
  logic [4:0]    ld_k_r;

  // tick scan
  logic [WC-1:0] sc_w_r;
  logic [4:0]    sc_i_r;
  logic [BW-1:0] budget_r;
  logic          pend_valid_r;
  logic [17:0]   pend_chunk_r;
  logic [3:0]    pend_piece_r;
  logic          pend_retx_r;

  logic                out_valid_r;
  logic [OUT_DW-1:0]   out_data_r;
  logic                out_user_r, out_last_r;

  // ---------------------------------------------------------------- decode
  logic [27:0]   rb_raw;
  logic [18:0]   rb_cl;
  logic [WI:0]   sc_sum;
  logic [WI-1:0] sc_phys, sel_phys;
  logic [AW-1:0] sc_addr, ld_addr, waddr;
  logic          mem_we;
  logic [31:0]   wdata;
  logic [31:0]   gap, age, atime_cur;
  logic          refuted;
  logic [15:0]   rev_bits, lim_mask;
  logic [31:0]   left;
  logic          ld_ok, ld_grow;
  logic [17:0]   sc_chunk;

  assign rb_raw = front_r[31:4] - 28'd1;
  assign rb_cl  = (rb_raw > {9'd0, ccount_r}) ? ccount_r : rb_raw[18:0];

  assign sc_sum  = (WI+1)'(head_r) + (WI+1)'(sc_w_r);
  assign sc_phys = (sc_sum >= (WI+1)'(W)) ? WI'(sc_sum - (WI+1)'(W)) : WI'(sc_sum);
  assign sel_phys = cmd.ack_apply ? head_r : sc_phys;
  assign sc_addr = AW'({sc_phys, sc_i_r[3:0]});
  assign ld_addr = AW'({ld_phys_r, 4'(ld_step_r - 5'd1)});
  assign sc_chunk = 18'(base_r + 19'(sc_w_r));

  assign atime_cur = atime_r[sel_phys];
  assign gap     = atime_cur - rd_r;
  assign age     = now_r - rd_r;
  assign refuted = (atime_cur != 32'd0) && !gap[31] && (gap >= {16'd0, fast_r});

  always_comb begin
    for (int i = 0; i < PIECES; i++) rev_bits[PIECES-1-i] = bits_r[i];
  end
  assign lim_mask = (pcs_r[head_r] >= 5'd16) ? 16'hffff
                  : ((16'd1 << pcs_r[head_r]) - 16'd1);

  assign left    = txlen_r - {ld_chunk_r[17:0], 14'd0};
  assign ld_ok   = ld_in_r && (ld_k_r <= 5'd16);
  assign ld_grow = ({1'b0, ld_acc_r} < {2'b0, ld_len_r}) && (ld_k_r <= 5'd16);

  assign mem_we = cmd.sc_take ||
                  (cmd.ld_run && ld_step_r >= 5'd1 && ld_step_r <= 5'd16);
  assign waddr  = cmd.sc_take ? sc_addr : ld_addr;
  assign wdata  = cmd.sc_take ? stamp(now_r) : 32'd0;

  always_comb begin
    stat               = '0;
    stat.op            = op_r;
    stat.active        = active_r;
    stat.start_bad     = active_r || (total_r == 32'd0);
    stat.ack_bad       = !active_r || (front_r[31:4] == 28'd0) || (front_r[3:0] != 4'd0);
    stat.at_frontier   = (rb_cl == base_r);
    stat.far_jump      = (rb_cl < base_r) ||
                         ({1'b0, rb_cl} >= ({1'b0, base_r} + 20'(W)));
    stat.ld_fin        = (ld_step_r == 5'(LD_STEPS)) && (ld_cnt_r == WC'(1));
    stat.sc_end        = (sc_w_r == WC'(W)) || (budget_r == '0);
    stat.sc_skip_slot  = !valid_r[sc_phys] || (sc_i_r >= pcs_r[sc_phys]);
    stat.sc_skip_piece = acked_r[sc_phys][sc_i_r[3:0]];
    stat.sc_emit       = (rd_r == 32'd0) || refuted || (age >= {16'd0, retx_r});
    stat.pend_valid    = pend_valid_r;
    stat.out_free      = !out_valid_r;
  end

  // --------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= 32'd1;
      stride_r     <= 11'd1100;
      retx_r       <= 16'd250;
      fast_r       <= 16'd50;
      burst_r      <= 6'd8;
      active_r     <= 1'b0;
      finished_r   <= 1'b0;
      ccount_r     <= '0;
      base_r       <= '0;
      head_r       <= '0;
      ld_cnt_r     <= '0;
      ld_step_r    <= '0;
      ld_phys_r    <= '0;
      ld_chunk_r   <= '0;
      sc_w_r       <= '0;
      sc_i_r       <= '0;
      budget_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int s = 0; s < W; s++) begin
        valid_r[s] <= 1'b0;
        pcs_r[s]   <= '0;
        acked_r[s] <= '0;
        atime_r[s] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TOTAL:  total_r  <= cfg_data;
          CFG_STRIDE: stride_r <= cfg_data[10:0];
          CFG_RETX:   retx_r   <= cfg_data[15:0];
          CFG_FAST:   fast_r   <= cfg_data[15:0];
          CFG_BURST:  burst_r  <= cfg_data[5:0];
          default: ;
        endcase
      end

      if (cmd.arm) begin
        active_r   <= 1'b1;
        finished_r <= 1'b0;
        ccount_r   <= {1'b0, total_r[31:14]} + 19'(|total_r[13:0]);
        base_r     <= '0;
        head_r     <= '0;
      end
      if (cmd.jump) begin
        base_r <= rb_cl;
        head_r <= '0;
      end
      if (cmd.shift) begin
        base_r     <= base_r + 19'd1;
        head_r     <= (head_r == WI'(W - 1)) ? '0 : head_r + WI'(1);
        ld_phys_r  <= head_r;
        ld_chunk_r <= {1'b0, base_r} + 20'(W);
        ld_cnt_r   <= WC'(1);
        ld_step_r  <= '0;
      end
      if (cmd.ld_all) begin
        ld_phys_r  <= '0;
        ld_chunk_r <= {1'b0, base_r};
        ld_cnt_r   <= WC'(W);
        ld_step_r  <= '0;
      end
      if (cmd.ld_run) begin
        if (ld_step_r == 5'(LD_STEPS)) begin
          valid_r[ld_phys_r] <= ld_ok;
          pcs_r[ld_phys_r]   <= ld_ok ? ld_k_r : 5'd0;
          acked_r[ld_phys_r] <= '0;
          atime_r[ld_phys_r] <= '0;
          ld_cnt_r   <= ld_cnt_r - WC'(1);
          ld_phys_r  <= ld_phys_r + WI'(1);
          ld_chunk_r <= ld_chunk_r + 20'd1;
          ld_step_r  <= '0;
        end else begin
          ld_step_r <= ld_step_r + 5'd1;
        end
      end

      if (cmd.ack_apply) begin
        if (valid_r[head_r]) begin
          acked_r[head_r] <= acked_r[head_r] | (rev_bits & lim_mask);
          atime_r[head_r] <= stamp(now_r);
        end
        if (base_r >= ccount_r) begin
          active_r   <= 1'b0;
          finished_r <= 1'b1;
        end
      end

      if (cmd.sc_init) begin
        sc_w_r       <= '0;
        sc_i_r       <= '0;
        pend_valid_r <= 1'b0;
        budget_r     <= ({26'd0, burst_r} > 32'(MAX_BURST)) ? BW'(MAX_BURST)
                                                            : BW'(burst_r);
      end
      if (cmd.sc_next_slot) begin
        sc_w_r <= sc_w_r + WC'(1);
        sc_i_r <= '0;
      end
      if (cmd.sc_next_piece) sc_i_r <= sc_i_r + 5'd1;
      if (cmd.sc_take) begin
        sc_i_r       <= sc_i_r + 5'd1;
        budget_r     <= budget_r - BW'(1);
        pend_valid_r <= 1'b1;
      end
      if (cmd.sc_flush) pend_valid_r <= 1'b0;

      if (cmd.push_status || cmd.sc_flush || (cmd.sc_take && pend_valid_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_tuser;
      front_r <= in_tdata[31:0];
      bits_r  <= in_tdata[47:32];
      now_r   <= in_tdata[79:48];
    end
    if (cmd.arm) txlen_r <= total_r;

    if (cmd.ld_run) begin
      if (ld_step_r == 5'd0) begin
        ld_in_r  <= (ld_chunk_r < {1'b0, ccount_r});
        ld_len_r <= (left > 32'(CHUNK_LEN)) ? 15'(CHUNK_LEN) : left[14:0];
        ld_acc_r <= '0;
        ld_k_r   <= '0;
      end else if (ld_step_r < 5'(LD_STEPS) && ld_grow) begin
        ld_acc_r <= ld_acc_r + {5'd0, stride_r};
        ld_k_r   <= ld_k_r + 5'd1;
      end
    end

    if (cmd.sc_take) begin
      pend_chunk_r <= sc_chunk;
      pend_piece_r <= sc_i_r[3:0];
      pend_retx_r  <= (rd_r != 32'd0);
    end

    if (cmd.push_status) begin
      out_user_r <= KIND_STATUS;
      out_last_r <= 1'b1;
      out_data_r <= {3'd0, finished_r, base_r, cmd.code, 1'b0, 4'd0, 18'd0};
    end else if (cmd.sc_flush || (cmd.sc_take && pend_valid_r)) begin
      out_user_r <= KIND_PIECE;
      out_last_r <= cmd.sc_flush;
      out_data_r <= {3'd0, finished_r, base_r, ST_OK, pend_retx_r, pend_piece_r,
                     pend_chunk_r};
    end

    if (mem_we) sent_mem[waddr] <= wdata;
    if (cmd.sc_read) rd_r <= sent_mem[sc_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: hw/rtl/selective_repeat_sender_window.sv
// Top level of the selective-repeat sender window; joins srsw_ctrl and
// srsw_dp. Depends on srsw_pkg.
//
// Sender side of a chunked selective-repeat transfer. One item is worked on
// at a time: in_tready is high only while the controller is idle. A start
// reloads all W chunk slots, each by a repeated-add piece counter that also
// clears the slot's 16 send stamps, before the status transfer is offered.
// An ack at the window base is applied directly; a short forward move first
// shifts the window and reloads one slot per chunk, and a move outside the
// window reloads every slot. A tick scans the window slot by slot, skipping
// empty slots and acked pieces and reading the send stamp of each examined
// piece (the send-stamp memory read is registered), and waits while the
// receiver holds the output register full. A result may wait in the output
// register while the next item is accepted. Config writes are taken every
// cycle and must happen only while no transfer item is in flight.
module selective_repeat_sender_window #(
  parameter int WINDOW    = 8,
  parameter int MAX_BURST = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // in_tdata: ack_frontier[31:0], ack_bits[47:32], now_ms[79:48]
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [srsw_pkg::IN_DW-1:0]   in_tdata,
  input  logic [1:0]                   in_tuser,   // op
  // out_tdata: piece_chunk[17:0], piece_index[21:18], retransmit[22],
  //            status[24:23], base_chunk[43:25], done_res[44], zero[47:45]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [srsw_pkg::OUT_DW-1:0]  out_tdata,
  output logic                         out_tuser,  // kind
  output logic                         out_tlast,  // last
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import srsw_pkg::*;

  srsw_cmd_t  cmd;
  srsw_stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  srsw_dp #(
    .W         (WINDOW),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
